// ===== src/ilir_pkg.sv =====
// Shared types and constants for the indexed list with shifting insert and remove.
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    localparam int IN_FIELDS_W  = MODE_W + CNT_W + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + STAT_W + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_INSERT    = 3'd1,
        MODE_POP_FIRST = 3'd2,
        MODE_REMOVE_AT = 3'd3,
        MODE_READ      = 3'd4,
        MODE_WRITE     = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== src/ilir_cell.sv =====
// One storage cell of the list row; loads from a neighbor, the new value, or holds.
`timescale 1ns / 1ps

module ilir_cell
    import ilir_pkg::*;
(
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [CNT_W-1:0]  idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (idx > cmd.pos) begin
                    data_next = left_data;
                end else if (idx == cmd.pos) begin
                    data_next = cmd.value;
                end
            end
            OP_REMOVE: begin
                if (idx >= cmd.pos) begin
                    data_next = right_data;
                end
            end
            OP_WRITE: begin
                if (idx == cmd.pos) begin
                    data_next = cmd.value;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/indexed_list_insert_remove.sv =====
// Top level: request decode, entry count, row of list cells and result register.
//
//  channel | ports                  | tdata fields (lowest bit first)
//  input   | s_tvalid/s_tready/s_tdata | mode, position, value
//  result  | m_tvalid/m_tready/m_tdata | data_out, status, count, is_empty
//
// Every cell of the row shifts or loads at the same clock edge, so one
// transaction can be taken per cycle while the result register can accept it.
// The result sits in an output register; a new request is taken whenever that
// register is empty or is being emptied in the same cycle.
// Reset clears the count and the result valid; cell contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // mode, position, value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // data_out, status, count, is_empty
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [DATA_W-1:0] data_out_reg;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic              accept;
    mode_t             mode;
    logic [CNT_W-1:0]  position;
    logic [DATA_W-1:0] value;

    cell_cmd_t         cmd;
    status_t           status;
    logic [DATA_W-1:0] data_out;
    logic              do_shift_read;
    logic [CNT_W-1:0]  read_pos;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] read_word;

    assign mode     = mode_t'(s_tdata[MODE_W-1:0]);
    assign position = s_tdata[MODE_W +: CNT_W];
    assign value    = s_tdata[MODE_W + CNT_W +: DATA_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign read_word = cell_data[read_pos[IDX_W-1:0]];

    // Request decode: status, count update and the command for the row.
    always_comb begin
        status        = ST_OK;
        count_next    = count_reg;
        cmd.op        = OP_NONE;
        cmd.pos       = position;
        cmd.value     = value;
        do_shift_read = 1'b0;
        read_pos      = position;
        unique case (mode)
            MODE_APPEND: begin
                if (count_reg == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    cmd.op     = OP_INSERT;
                    cmd.pos    = count_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (position > count_reg) begin
                    status = ST_BADPOS;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP_FIRST: begin
                read_pos = '0;
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.op        = OP_REMOVE;
                    cmd.pos       = '0;
                    do_shift_read = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            MODE_REMOVE_AT: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (position >= count_reg) begin
                    status = ST_BADPOS;
                end else begin
                    cmd.op        = OP_REMOVE;
                    do_shift_read = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (position >= count_reg) begin
                    status = ST_BADPOS;
                end else begin
                    do_shift_read = 1'b1;
                end
            end
            MODE_WRITE: begin
                if (position >= count_reg) begin
                    status = ST_BADPOS;
                end else begin
                    cmd.op = OP_WRITE;
                end
            end
            default: status = ST_OK;
        endcase
        if (!accept) begin
            cmd.op     = OP_NONE;
            count_next = count_reg;
        end
        data_out = do_shift_read ? read_word : '0;
    end

    // The row of cells; each end cell sees its own word beyond the edge.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = cell_data[i];
        end else begin : g_left
            assign left_data = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_right
            assign right_data = cell_data[i+1];
        end

        ilir_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .idx        (CNT_W'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_out_reg  <= data_out;
            status_reg    <= status;
            count_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       (count_out_reg == '0),
                       count_out_reg,
                       status_reg,
                       data_out_reg};

endmodule
